// File: rtl/fpa_pkg.sv
package fpa_pkg;

    // Width of the word fields on the ports
    localparam int WORD_WIDTH = 32;

    // Defaults for the top-level parameters
    localparam int FRAC_BITS_DEFAULT  = 8;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OPCODE_WIDTH = 4;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_EQ      = 4'd4,
        OP_NE      = 4'd5,
        OP_GT      = 4'd6,
        OP_LT      = 4'd7,
        OP_GE      = 4'd8,
        OP_LE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_FROMINT = 4'd14,
        OP_TOINT   = 4'd15
    } opcode_t;

endpackage

// File: rtl/fpa_div_cell.sv
// One restoring-division step: shift in a dividend bit, subtract divisor
// if it fits, shift the quotient bit in. Side data rides along unchanged.
module fpa_div_cell #(
    parameter int DW     = 32,
    parameter int NQ     = 40,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DW-1:0]     in_rem,
    input  logic [NQ-1:0]     in_qd,
    input  logic [DW-1:0]     in_dvs,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DW-1:0]     out_rem,
    output logic [NQ-1:0]     out_qd,
    output logic [DW-1:0]     out_dvs,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     rem_next;
    logic [NQ-1:0]     qd_reg;
    logic [NQ-1:0]     qd_next;
    logic [DW-1:0]     dvs_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [DW:0]       rem_sh;
    logic [DW:0]       dvs_ext;
    logic              fits;

    // Compare-subtract step
    always_comb
    begin
        rem_sh   = {in_rem, in_qd[NQ-1]};
        dvs_ext  = {1'b0, in_dvs};
        fits     = (rem_sh >= dvs_ext);
        rem_next = fits ? DW'(rem_sh - dvs_ext) : DW'(rem_sh);
        qd_next  = {in_qd[NQ-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            qd_reg   <= qd_next;
            dvs_reg  <= in_dvs;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_qd    = qd_reg;
    assign out_dvs   = dvs_reg;
    assign out_side  = side_reg;

endmodule

// File: rtl/fpa_front.sv
// Entry stage: decode, simple operations, multiplier, divider setup.
module fpa_front #(
    parameter int DW = 32,
    parameter int FB = 8,
    parameter int NQ = 40
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [3:0]                opcode,
    input  logic [DW-1:0]             a_word,
    input  logic [DW-1:0]             b_word,
    output logic                      out_valid,
    output logic [3:0]                out_op,
    output logic [DW-1:0]             out_simple,
    output logic                      out_cmp,
    output logic                      out_dz,
    output logic                      out_neg,
    output logic signed [2*DW-1:0]    out_prod,
    output logic [NQ-1:0]             out_dividend,
    output logic [DW-1:0]             out_divisor
);

    logic signed [DW-1:0]   a_s;
    logic signed [DW-1:0]   b_s;
    logic [DW-1:0]          mag_a;
    logic [DW-1:0]          mag_b;
    logic [DW-1:0]          simple_next;
    logic                   cmp_next;
    logic                   dz_next;
    logic                   neg_next;
    logic signed [2*DW-1:0] prod_next;
    logic [NQ-1:0]          dividend_next;

    logic                   valid_reg;
    logic [3:0]             op_reg;
    logic [DW-1:0]          simple_reg;
    logic                   cmp_reg;
    logic                   dz_reg;
    logic                   neg_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic [NQ-1:0]          dividend_reg;
    logic [DW-1:0]          divisor_reg;

    assign a_s = signed'(a_word);
    assign b_s = signed'(b_word);

    // Operand magnitudes for the divider
    assign mag_a         = a_word[DW-1] ? DW'(-a_word) : a_word;
    assign mag_b         = b_word[DW-1] ? DW'(-b_word) : b_word;
    assign dividend_next = NQ'(mag_a) << FB;
    assign neg_next      = a_word[DW-1] ^ b_word[DW-1];
    assign prod_next     = (2*DW)'(a_s) * (2*DW)'(b_s);

    // Simple operations and compares
    always_comb
    begin
        simple_next = '0;
        cmp_next    = 1'b0;
        dz_next     = 1'b0;
        unique case (fpa_pkg::opcode_t'(opcode))
            fpa_pkg::OP_ADD:     simple_next = a_word + b_word;
            fpa_pkg::OP_SUB:     simple_next = a_word - b_word;
            fpa_pkg::OP_MUL:     simple_next = '0;
            fpa_pkg::OP_DIV:     dz_next = (b_word == '0);
            fpa_pkg::OP_EQ:      cmp_next = (a_s == b_s);
            fpa_pkg::OP_NE:      cmp_next = (a_s != b_s);
            fpa_pkg::OP_GT:      cmp_next = (a_s > b_s);
            fpa_pkg::OP_LT:      cmp_next = (a_s < b_s);
            fpa_pkg::OP_GE:      cmp_next = (a_s >= b_s);
            fpa_pkg::OP_LE:      cmp_next = (a_s <= b_s);
            fpa_pkg::OP_MIN:     simple_next = (a_s > b_s) ? b_word : a_word;
            fpa_pkg::OP_MAX:     simple_next = (a_s > b_s) ? a_word : b_word;
            fpa_pkg::OP_INC:     simple_next = a_word + DW'(1);
            fpa_pkg::OP_DEC:     simple_next = a_word - DW'(1);
            fpa_pkg::OP_FROMINT: simple_next = a_word << FB;
            fpa_pkg::OP_TOINT:   simple_next = DW'(a_s >>> FB);
            default:             simple_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg       <= opcode;
            simple_reg   <= simple_next;
            cmp_reg      <= cmp_next;
            dz_reg       <= dz_next;
            neg_reg      <= neg_next;
            prod_reg     <= prod_next;
            dividend_reg <= dividend_next;
            divisor_reg  <= mag_b;
        end
    end

    assign out_valid    = valid_reg;
    assign out_op       = op_reg;
    assign out_simple   = simple_reg;
    assign out_cmp      = cmp_reg;
    assign out_dz       = dz_reg;
    assign out_neg      = neg_reg;
    assign out_prod     = prod_reg;
    assign out_dividend = dividend_reg;
    assign out_divisor  = divisor_reg;

endmodule

// File: rtl/fixed_point_alu.sv
// Structure: one entry stage, one divider cell per quotient bit, one output
// register. Throughput: one item per cycle unless the output stalls; every
// operation uses the same chain.
// A stalled output freezes the whole chain; in_ready = !out_valid || out_ready.
// Reset (rst_n, async, active low) clears all stage valid bits; no item is
// held after reset.
module fixed_point_alu #(
    parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEFAULT,
    parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [3:0]                             opcode,
    input  logic signed [fpa_pkg::WORD_WIDTH-1:0]  operand_a,
    input  logic signed [fpa_pkg::WORD_WIDTH-1:0]  operand_b,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [fpa_pkg::WORD_WIDTH-1:0]  result_word,
    output logic                                   compare_true,
    output logic                                   divide_by_zero
);

    localparam int DW     = DATA_WIDTH;
    localparam int NQ     = DATA_WIDTH + FRAC_BITS;
    localparam int SIDE_W = 4 + DW + 3 + 2 * DW;

    logic                   en;
    logic                   f_valid;
    logic [3:0]             f_op;
    logic [DW-1:0]          f_simple;
    logic                   f_cmp;
    logic                   f_dz;
    logic                   f_neg;
    logic signed [2*DW-1:0] f_prod;
    logic [NQ-1:0]          f_dividend;
    logic [DW-1:0]          f_divisor;

    logic                   c_valid [NQ+1];
    logic [DW-1:0]          c_rem   [NQ+1];
    logic [NQ-1:0]          c_qd    [NQ+1];
    logic [DW-1:0]          c_dvs   [NQ+1];
    logic [SIDE_W-1:0]      c_side  [NQ+1];

    logic [3:0]             b_op;
    logic [DW-1:0]          b_simple;
    logic                   b_cmp;
    logic                   b_dz;
    logic                   b_neg;
    logic signed [2*DW-1:0] b_prod;
    logic signed [2*DW-1:0] prod_adj;
    logic [DW-1:0]          quo;
    logic [DW-1:0]          res_w;
    logic signed [DW-1:0]   res_s;

    logic                              valid_reg;
    logic signed [fpa_pkg::WORD_WIDTH-1:0] result_reg;
    logic                              cmp_reg;
    logic                              dz_reg;

    // Global advance: the chain moves unless a held result is not taken
    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    fpa_front #(
        .DW (DW),
        .FB (FRAC_BITS),
        .NQ (NQ)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .opcode       (opcode),
        .a_word       (operand_a[DW-1:0]),
        .b_word       (operand_b[DW-1:0]),
        .out_valid    (f_valid),
        .out_op       (f_op),
        .out_simple   (f_simple),
        .out_cmp      (f_cmp),
        .out_dz       (f_dz),
        .out_neg      (f_neg),
        .out_prod     (f_prod),
        .out_dividend (f_dividend),
        .out_divisor  (f_divisor)
    );

    assign c_valid[0] = f_valid;
    assign c_rem[0]   = '0;
    assign c_qd[0]    = f_dividend;
    assign c_dvs[0]   = f_divisor;
    assign c_side[0]  = {f_op, f_simple, f_cmp, f_dz, f_neg, f_prod};

    // Divider chain, one quotient bit per cell
    for (genvar i = 0; i < NQ; i++)
    begin : g_cell
        fpa_div_cell #(
            .DW     (DW),
            .NQ     (NQ),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_rem    (c_rem[i]),
            .in_qd     (c_qd[i]),
            .in_dvs    (c_dvs[i]),
            .in_side   (c_side[i]),
            .out_valid (c_valid[i+1]),
            .out_rem   (c_rem[i+1]),
            .out_qd    (c_qd[i+1]),
            .out_dvs   (c_dvs[i+1]),
            .out_side  (c_side[i+1])
        );
    end

    assign {b_op, b_simple, b_cmp, b_dz, b_neg, b_prod} = c_side[NQ];

    // Final select: multiply rounding toward zero, divide sign fix-up
    always_comb
    begin
        prod_adj = b_prod;
        if (b_prod[2*DW-1])
        begin
            prod_adj = b_prod + (2*DW)'((64'd1 << FRAC_BITS) - 64'd1);
        end
        quo = c_qd[NQ][DW-1:0];
        case (fpa_pkg::opcode_t'(b_op))
            fpa_pkg::OP_MUL: res_w = DW'(prod_adj >>> FRAC_BITS);
            fpa_pkg::OP_DIV: res_w = b_dz ? '0 : (b_neg ? DW'(-quo) : quo);
            default:         res_w = b_simple;
        endcase
        res_s = signed'(res_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= c_valid[NQ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= fpa_pkg::WORD_WIDTH'(res_s);
            cmp_reg    <= b_cmp;
            dz_reg     <= b_dz;
        end
    end

    assign out_valid      = valid_reg;
    assign result_word    = result_reg;
    assign compare_true   = cmp_reg;
    assign divide_by_zero = dz_reg;

    // Checks
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_word == '0)
        else $error("divide by zero with nonzero result");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(compare_true && divide_by_zero))
        else $error("compare and divide-by-zero flags both set");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_word))
        else $error("stalled result lost");

endmodule
